// File: rtl/esc_pkg.sv
`default_nettype none

package esc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_B   = 3'd5;

  // divisor magnitude after the >>> 33 stays below 2^31
  localparam int DEN_W    = 31;
  localparam int DIV_BITS = 64;

  // humidity chain depth
  localparam int HUM_STAGES = 8;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } cal_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [16:0] hum;
  } side_t;

  typedef struct packed {
    logic  neg;
    logic  nz;
    side_t side;
  } tag_t;

  typedef struct packed {
    logic [63:0]      num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             neg;
    logic             nz;
  } pre_t;

endpackage

`default_nettype wire

// File: rtl/esc_temp.sv
`default_nettype none

module esc_temp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [19:0]         raw_temp,
  input  logic [19:0]         raw_press,
  input  logic [15:0]         raw_hum,
  input  esc_pkg::cal_t       cal,
  output logic                o_vld,
  output logic [31:0]         o_tf,
  output logic [31:0]         o_tc,
  output logic [19:0]         o_ap,
  output logic [15:0]         o_ah
);
  import esc_pkg::*;

  logic [4:0]  v_r;
  logic [19:0] at0_r;
  logic [19:0] ap_r [5];
  logic [15:0] ah_r [5];
  logic [31:0] dd1_r, m1_r, v1_2_r, mt3_r, tf3_r, tf4_r, tc4_r;

  logic signed [17:0] d_s, e_s;
  logic signed [35:0] dd_w;
  logic signed [33:0] m1_w;
  logic [31:0]        v1_w, dds_w, v2_w, t5_w, tc_w;
  logic signed [35:0] mt3_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_vld};
    end
  end

  // stage 1: d^2 and (at/8 - 2*T1)*T2
  assign d_s  = $signed({2'b00, at0_r[19:4]}) - $signed({2'b00, cal.t1});
  assign e_s  = $signed({1'b0, at0_r[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign dd_w = d_s * d_s;
  assign m1_w = e_s * $signed(cal.t2);

  // stage 2
  assign v1_w  = $signed(m1_r) >>> 11;
  assign dds_w = $signed(dd1_r) >>> 12;
  assign mt3_w = $signed(dds_w[19:0]) * $signed(cal.t3);

  // stage 3
  assign v2_w = $signed(mt3_r) >>> 14;

  // stage 4
  assign t5_w = tf3_r * 32'd5 + 32'd128;
  assign tc_w = $signed(t5_w) >>> 8;

  always_ff @(posedge clk) begin
    at0_r  <= raw_temp;
    ap_r[0] <= raw_press;
    ah_r[0] <= raw_hum;
    for (int k = 1; k < 5; k++) begin
      ap_r[k] <= ap_r[k-1];
      ah_r[k] <= ah_r[k-1];
    end
    dd1_r  <= dd_w[31:0];
    m1_r   <= m1_w[31:0];
    v1_2_r <= v1_w;
    mt3_r  <= mt3_w[31:0];
    tf3_r  <= v1_2_r + v2_w;
    tf4_r  <= tf3_r;
    tc4_r  <= tc_w;
  end

  assign o_vld = v_r[4];
  assign o_tf  = tf4_r;
  assign o_tc  = tc4_r;
  assign o_ap  = ap_r[4];
  assign o_ah  = ah_r[4];

endmodule

`default_nettype wire

// File: rtl/esc_hum.sv
`default_nettype none

module esc_hum (
  input  logic          clk,
  input  logic [31:0]   tf,
  input  logic [31:0]   tc,
  input  logic [15:0]   ah,
  input  esc_pkg::cal_t cal,
  output esc_pkg::side_t o_side
);
  import esc_pkg::*;

  logic [31:0] tc_r [HUM_STAGES];
  logic [31:0] mh5_r, mh6_r, mh3_r, base_r;
  logic [31:0] hx2_r, hy2_r, hz2_r, m3_r, hx3_r, mh2_r, hx4_r;
  logic [31:0] x2_5_r, qq_r, x2_6_r, t7_r, x2_7_r;
  logic [16:0] hum_r;

  logic [31:0]        x_w, base_w;
  logic signed [43:0] h5_w;
  logic signed [39:0] h6_w;
  logic signed [40:0] h3_w;
  logic [31:0]        hxs_w, hx_w, hy_w, hz0_w;
  logic [31:0]        hw0_w, hw_w, hv0_w, hv_w, q_w, qs_w, ts_w, x3_w, xc_w;

  // stage 1
  assign x_w    = tf - 32'd76800;
  assign h5_w   = $signed(x_w) * $signed(cal.h5);
  assign h6_w   = $signed(x_w) * $signed(cal.h6);
  assign h3_w   = $signed(x_w) * $signed({1'b0, cal.h3});
  assign base_w = {2'b00, ah, 14'd0} - {cal.h4, 20'd0};

  // stage 2
  assign hxs_w = base_r - mh5_r + 32'd16384;
  assign hx_w  = $signed(hxs_w) >>> 15;
  assign hy_w  = $signed(mh6_r) >>> 10;
  assign hz0_w = $signed(mh3_r) >>> 11;

  // stage 4
  assign hw0_w = $signed(m3_r) >>> 10;
  assign hw_w  = hw0_w + 32'd2097152;

  // stage 5
  assign hv0_w = mh2_r + 32'd8192;
  assign hv_w  = $signed(hv0_w) >>> 14;

  // stage 6, 7
  assign q_w  = $signed(x2_5_r) >>> 15;
  assign qs_w = $signed(qq_r) >>> 7;

  // stage 8: subtract and clamp
  assign ts_w = $signed(t7_r) >>> 4;
  assign x3_w = x2_7_r - ts_w;

  always_comb begin
    priority if (x3_w[31]) begin
      xc_w = '0;
    end else if (x3_w > HUM_MAX) begin
      xc_w = HUM_MAX;
    end else begin
      xc_w = x3_w;
    end
  end

  always_ff @(posedge clk) begin
    tc_r[0] <= tc;
    for (int k = 1; k < HUM_STAGES; k++) begin
      tc_r[k] <= tc_r[k-1];
    end
    mh5_r  <= h5_w[31:0];
    mh6_r  <= h6_w[31:0];
    mh3_r  <= h3_w[31:0];
    base_r <= base_w;
    hx2_r  <= hx_w;
    hy2_r  <= hy_w;
    hz2_r  <= hz0_w + 32'd32768;
    m3_r   <= hy2_r * hz2_r;
    hx3_r  <= hx2_r;
    mh2_r  <= hw_w * {{16{cal.h2[15]}}, cal.h2};
    hx4_r  <= hx3_r;
    x2_5_r <= hx4_r * hv_w;
    qq_r   <= q_w * q_w;
    x2_6_r <= x2_5_r;
    t7_r   <= qs_w * {24'd0, cal.h1};
    x2_7_r <= x2_6_r;
    hum_r  <= xc_w[28:12];
  end

  assign o_side.tc  = tc_r[HUM_STAGES-1];
  assign o_side.hum = hum_r;

endmodule

`default_nettype wire

// File: rtl/esc_ppre.sv
`default_nettype none

module esc_ppre (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [31:0]   tf,
  input  logic [19:0]   ap,
  input  esc_pkg::cal_t cal,
  output logic          o_vld,
  output esc_pkg::pre_t o_pre
);
  import esc_pkg::*;

  logic [7:0]  v_r;
  logic [19:0] raw_r [4];
  logic [63:0] aa1_r;
  logic [48:0] ap5_r [2];
  logic [48:0] ap2_r [2];
  logic [48:0] p6lo_r, p3lo_r;
  logic [47:0] p6hi_r, p3hi_r;
  logic [63:0] b1_r, a2_r, b4_r;
  logic [47:0] p1lo_r;
  logic [48:0] p1hi_r;
  logic [63:0] a3_r [3];
  logic [63:0] num0_r, num7_r;
  logic [43:0] nlo_r;
  logic [31:0] nhi_r;
  pre_t        pre_r;

  logic signed [32:0] a_w;
  logic signed [65:0] aa_w;
  logic signed [48:0] ap5_w, ap2_w, p6lo_w, p3lo_w, p1hi_w;
  logic signed [47:0] p6hi_w, p3hi_w;
  logic [63:0]        prod6_w, prod3_w, a3s_w, b1_w, a2_w, b_w, ax_w, a3f_w, a3_w;
  logic [63:0]        num0_w, dmag_w;
  logic [47:0]        p1lo_w;
  logic [20:0]        pr_w;
  logic [43:0]        nlo_w;
  logic [31:0]        nhi_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[6:0], in_vld};
    end
  end

  // stage 1: a = tf - 128000 and its products
  assign a_w   = $signed({tf[31], tf}) - 33'sd128000;
  assign aa_w  = a_w * a_w;
  assign ap5_w = a_w * $signed(cal.p5);
  assign ap2_w = a_w * $signed(cal.p2);

  // stage 2: 64x16 products as two 32x16 partials
  assign p6lo_w = $signed({1'b0, aa1_r[31:0]}) * $signed(cal.p6);
  assign p6hi_w = $signed(aa1_r[63:32]) * $signed(cal.p6);
  assign p3lo_w = $signed({1'b0, aa1_r[31:0]}) * $signed(cal.p3);
  assign p3hi_w = $signed(aa1_r[63:32]) * $signed(cal.p3);

  // stage 3
  assign prod6_w = {{15{p6lo_r[48]}}, p6lo_r} + {p6hi_r[31:0], 32'd0};
  assign prod3_w = {{15{p3lo_r[48]}}, p3lo_r} + {p3hi_r[31:0], 32'd0};
  assign b1_w    = prod6_w + ({{15{ap5_r[1][48]}}, ap5_r[1]} << 17);
  assign a3s_w   = $signed(prod3_w) >>> 8;
  assign a2_w    = a3s_w + ({{15{ap2_r[1][48]}}, ap2_r[1]} << 12);

  // stage 4
  assign b_w    = b1_r + ({{48{cal.p4[15]}}, cal.p4} << 35);
  assign ax_w   = a2_r + 64'h0000_8000_0000_0000;
  assign p1lo_w = ax_w[31:0] * cal.p1;
  assign p1hi_w = $signed(ax_w[63:32]) * $signed({1'b0, cal.p1});

  // stage 5: divisor, numerator before scaling
  assign a3f_w  = {16'd0, p1lo_r} + {p1hi_r[31:0], 32'd0};
  assign a3_w   = $signed(a3f_w) >>> 33;
  assign pr_w   = 21'd1048576 - {1'b0, raw_r[3]};
  assign num0_w = {12'd0, pr_w, 31'd0} - b4_r;

  // stage 6: times 3125
  assign nlo_w = num0_r[31:0] * 12'd3125;
  assign nhi_w = num0_r[63:32] * 32'd3125;

  // stage 8: signs and magnitudes
  assign dmag_w = a3_r[2][63] ? (64'd0 - a3_r[2]) : a3_r[2];

  always_ff @(posedge clk) begin
    raw_r[0] <= ap;
    for (int k = 1; k < 4; k++) begin
      raw_r[k] <= raw_r[k-1];
    end
    aa1_r    <= aa_w[63:0];
    ap5_r[0] <= ap5_w;
    ap5_r[1] <= ap5_r[0];
    ap2_r[0] <= ap2_w;
    ap2_r[1] <= ap2_r[0];
    p6lo_r   <= p6lo_w;
    p6hi_r   <= p6hi_w;
    p3lo_r   <= p3lo_w;
    p3hi_r   <= p3hi_w;
    b1_r     <= b1_w;
    a2_r     <= a2_w;
    b4_r     <= b_w;
    p1lo_r   <= p1lo_w;
    p1hi_r   <= p1hi_w;
    a3_r[0]  <= a3_w;
    a3_r[1]  <= a3_r[0];
    a3_r[2]  <= a3_r[1];
    num0_r   <= num0_w;
    nlo_r    <= nlo_w;
    nhi_r    <= nhi_w;
    num7_r   <= {20'd0, nlo_r} + {nhi_r, 32'd0};
    pre_r.num_mag <= num7_r[63] ? (64'd0 - num7_r) : num7_r;
    pre_r.den_mag <= dmag_w[DEN_W-1:0];
    pre_r.neg     <= num7_r[63] ^ a3_r[2][63];
    pre_r.nz      <= |a3_r[2];
  end

  assign o_vld = v_r[7];
  assign o_pre = pre_r;

endmodule

`default_nettype wire

// File: rtl/esc_div.sv
`default_nettype none

module esc_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  esc_pkg::pre_t  pre,
  input  esc_pkg::side_t side,
  output logic           o_vld,
  output logic [63:0]    o_quo,
  output esc_pkg::tag_t  o_tag
);
  import esc_pkg::*;

  // one quotient bit per stage, restoring
  logic [DIV_BITS-1:0] v_r;
  logic [DEN_W-1:0]    rem_r [DIV_BITS];
  logic [63:0]         dq_r  [DIV_BITS];
  logic [DEN_W-1:0]    den_r [DIV_BITS];
  tag_t                tag_r [DIV_BITS];
  tag_t                tag_in;

  assign tag_in.neg  = pre.neg;
  assign tag_in.nz   = pre.nz;
  assign tag_in.side = side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DIV_BITS-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [DEN_W-1:0] rem_prev, den_prev;
    logic [63:0]      dq_prev;
    tag_t             tag_prev;
    logic [DEN_W:0]   sh, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign dq_prev  = pre.num_mag;
      assign den_prev = pre.den_mag;
      assign tag_prev = tag_in;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign dq_prev  = dq_r[k-1];
      assign den_prev = den_r[k-1];
      assign tag_prev = tag_r[k-1];
    end

    assign sh   = {rem_prev, dq_prev[63]};
    assign diff = sh - {1'b0, den_prev};
    assign ge   = (sh >= {1'b0, den_prev});

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      dq_r[k]  <= {dq_prev[62:0], ge};
      den_r[k] <= den_prev;
      tag_r[k] <= tag_prev;
    end
  end

  assign o_vld = v_r[DIV_BITS-1];
  assign o_quo = dq_r[DIV_BITS-1];
  assign o_tag = tag_r[DIV_BITS-1];

endmodule

`default_nettype wire

// File: rtl/esc_ppost.sv
`default_nettype none

module esc_ppost (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [63:0]   quo,
  input  esc_pkg::tag_t tag,
  input  esc_pkg::cal_t cal,
  output logic          o_strobe,
  output logic [31:0]   o_temp_centi,
  output logic [31:0]   o_press_q8,
  output logic          o_press_ok,
  output logic [16:0]   o_hum_q10
);
  import esc_pkg::*;

  logic [4:0]  v_r;
  tag_t        tag_r [5];
  logic [63:0] p_r [4];
  logic [51:0] hh_r, hl_r;
  logic [49:0] ll_r;
  logic [48:0] p8lo_r, p9lo_r;
  logic [47:0] p8hi_r, p9hi_r;
  logic [63:0] ss_r, c2_r [2], sum_r;
  logic        strobe_r, ok_r;
  logic [31:0] temp_r, press_r;
  logic [16:0] hum_r;

  logic [63:0]        s_w, ss_w, c2f_w, c2_w, c1f_w, c1_w, r0_w, r_w;
  logic [31:0]        sat_w;
  logic signed [51:0] hh_w, hl_w;
  logic [49:0]        ll_w;
  logic signed [48:0] p8lo_w, p9lo_w;
  logic signed [47:0] p8hi_w, p9hi_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      v_r      <= {v_r[3:0], in_vld};
      strobe_r <= v_r[4];
    end
  end

  // stage 2: s = p >>> 13 squared in 26/25-bit halves; p*P8 partials
  assign s_w    = $signed(p_r[0]) >>> 13;
  assign hh_w   = $signed(s_w[50:25]) * $signed(s_w[50:25]);
  assign hl_w   = $signed(s_w[50:25]) * $signed({1'b0, s_w[24:0]});
  assign ll_w   = s_w[24:0] * s_w[24:0];
  assign p8lo_w = $signed({1'b0, p_r[0][31:0]}) * $signed(cal.p8);
  assign p8hi_w = $signed(p_r[0][63:32]) * $signed(cal.p8);

  // stage 3
  assign ss_w  = ({{12{hh_r[51]}}, hh_r} << 50) + ({{12{hl_r[51]}}, hl_r} << 26)
               + {14'd0, ll_r};
  assign c2f_w = {{15{p8lo_r[48]}}, p8lo_r} + {p8hi_r[31:0], 32'd0};
  assign c2_w  = $signed(c2f_w) >>> 19;

  // stage 4
  assign p9lo_w = $signed({1'b0, ss_r[31:0]}) * $signed(cal.p9);
  assign p9hi_w = $signed(ss_r[63:32]) * $signed(cal.p9);

  // stage 5
  assign c1f_w = {{15{p9lo_r[48]}}, p9lo_r} + {p9hi_r[31:0], 32'd0};
  assign c1_w  = $signed(c1f_w) >>> 25;

  // stage 6: scale, offset, saturate
  assign r0_w = $signed(sum_r) >>> 8;
  assign r_w  = r0_w + ({{48{cal.p7[15]}}, cal.p7} << 4);

  always_comb begin
    priority if (r_w[63]) begin
      sat_w = '0;
    end else if (|r_w[62:32]) begin
      sat_w = '1;
    end else begin
      sat_w = r_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= tag;
    for (int k = 1; k < 5; k++) begin
      tag_r[k] <= tag_r[k-1];
    end
    p_r[0]  <= tag.neg ? (64'd0 - quo) : quo;
    for (int k = 1; k < 4; k++) begin
      p_r[k] <= p_r[k-1];
    end
    hh_r    <= hh_w;
    hl_r    <= hl_w;
    ll_r    <= ll_w;
    p8lo_r  <= p8lo_w;
    p8hi_r  <= p8hi_w;
    ss_r    <= ss_w;
    c2_r[0] <= c2_w;
    c2_r[1] <= c2_r[0];
    p9lo_r  <= p9lo_w;
    p9hi_r  <= p9hi_w;
    sum_r   <= p_r[3] + c1_w + c2_r[1];
    temp_r  <= tag_r[4].side.tc;
    hum_r   <= tag_r[4].side.hum;
    ok_r    <= tag_r[4].nz;
    press_r <= tag_r[4].nz ? sat_w : 32'd0;
  end

  assign o_strobe     = strobe_r;
  assign o_temp_centi = temp_r;
  assign o_press_q8   = press_r;
  assign o_press_ok   = ok_r;
  assign o_hum_q10    = hum_r;

endmodule

`default_nettype wire

// File: rtl/env_sensor_compensation.sv
// Environmental sensor compensation, fully pipelined.
//
// Input: one set of raw readings (in_raw_temp, in_raw_press, in_raw_hum)
// is transferred at each rising edge where start is high and busy is low.
// busy is always low: a new set may be started every cycle.
// Output: out_strobe is high for exactly one cycle per input set, with
// out_temp_centi (0.01 degC), out_press_q8 (Pa, Q24.8, saturated),
// out_press_ok (low when the pressure divisor was zero, pressure then 0)
// and out_hum_q10 (%RH, Q7.10). Results leave in input order.
// The pipeline holds 13 stages of temperature, humidity and pressure
// setup, 64 stages of the bit-per-stage pressure divider and 6 stages of
// pressure correction.
// Throughput: one set per cycle; the divider chain sets the depth.
// The receiver cannot stall; results are never held.
// Config: cfg_valid/cfg_ready (ready always high), cfg_index selects the
// calibration word, indexes past the last word are dropped. Write only
// while no set is in flight.
// Reset (rst_n low, synchronous) clears all calibration words and drops
// any sets in flight.

`default_nettype none

module env_sensor_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           start,
  output logic                           busy,
  input  logic [19:0]                    in_raw_temp,
  input  logic [19:0]                    in_raw_press,
  input  logic [15:0]                    in_raw_hum,
  // result channel
  output logic                           out_strobe,
  output logic [31:0]                    out_temp_centi,
  output logic [31:0]                    out_press_q8,
  output logic                           out_press_ok,
  output logic [16:0]                    out_hum_q10,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import esc_pkg::*;

  // calibration words
  logic [47:0] temp_cal_r, press_cal_a_r, press_cal_b_r, press_cal_c_r;
  logic [31:0] hum_cal_a_r, hum_cal_b_r;
  cal_t        cal;

  // inter-module links
  logic        t_vld;
  logic [31:0] t_tf, t_tc;
  logic [19:0] t_ap;
  logic [15:0] t_ah;
  side_t       h_side;
  logic        pp_vld;
  pre_t        pp_pre;
  logic        d_vld;
  logic [63:0] d_quo;
  tag_t        d_tag;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r    <= '0;
      press_cal_a_r <= '0;
      press_cal_b_r <= '0;
      press_cal_c_r <= '0;
      hum_cal_a_r   <= '0;
      hum_cal_b_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP_CAL:    temp_cal_r    <= cfg_wdata;
        REG_PRESS_CAL_A: press_cal_a_r <= cfg_wdata;
        REG_PRESS_CAL_B: press_cal_b_r <= cfg_wdata;
        REG_PRESS_CAL_C: press_cal_c_r <= cfg_wdata;
        REG_HUM_CAL_A:   hum_cal_a_r   <= cfg_wdata[31:0];
        REG_HUM_CAL_B:   hum_cal_b_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // unpack calibration fields
  assign cal.t1 = temp_cal_r[15:0];
  assign cal.t2 = temp_cal_r[31:16];
  assign cal.t3 = temp_cal_r[47:32];
  assign cal.p1 = press_cal_a_r[15:0];
  assign cal.p2 = press_cal_a_r[31:16];
  assign cal.p3 = press_cal_a_r[47:32];
  assign cal.p4 = press_cal_b_r[15:0];
  assign cal.p5 = press_cal_b_r[31:16];
  assign cal.p6 = press_cal_b_r[47:32];
  assign cal.p7 = press_cal_c_r[15:0];
  assign cal.p8 = press_cal_c_r[31:16];
  assign cal.p9 = press_cal_c_r[47:32];
  assign cal.h1 = hum_cal_a_r[7:0];
  assign cal.h2 = hum_cal_a_r[23:8];
  assign cal.h3 = hum_cal_a_r[31:24];
  assign cal.h4 = hum_cal_b_r[11:0];
  assign cal.h5 = hum_cal_b_r[23:12];
  assign cal.h6 = hum_cal_b_r[31:24];

  // fine temperature and 0.01 degC result (5 stages incl. input register)
  esc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start && !busy),
    .raw_temp  (in_raw_temp),
    .raw_press (in_raw_press),
    .raw_hum   (in_raw_hum),
    .cal       (cal),
    .o_vld     (t_vld),
    .o_tf      (t_tf),
    .o_tc      (t_tc),
    .o_ap      (t_ap),
    .o_ah      (t_ah)
  );

  // humidity chain, 8 stages, carries the temperature result along
  esc_hum u_hum (
    .clk    (clk),
    .tf     (t_tf),
    .tc     (t_tc),
    .ah     (t_ah),
    .cal    (cal),
    .o_side (h_side)
  );

  // pressure numerator and divisor, 8 stages, lines up with humidity
  esc_ppre u_ppre (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (t_vld),
    .tf     (t_tf),
    .ap     (t_ap),
    .cal    (cal),
    .o_vld  (pp_vld),
    .o_pre  (pp_pre)
  );

  // unsigned magnitude divide, one quotient bit per stage
  esc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (pp_vld),
    .pre    (pp_pre),
    .side   (h_side),
    .o_vld  (d_vld),
    .o_quo  (d_quo),
    .o_tag  (d_tag)
  );

  // sign, P7..P9 correction, saturation, output register
  esc_ppost u_ppost (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (d_vld),
    .quo          (d_quo),
    .tag          (d_tag),
    .cal          (cal),
    .o_strobe     (out_strobe),
    .o_temp_centi (out_temp_centi),
    .o_press_q8   (out_press_q8),
    .o_press_ok   (out_press_ok),
    .o_hum_q10    (out_hum_q10)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

// Testbench for env_sensor_compensation.
// Raw reading sets are transferred on start/busy; every set gives exactly one
// compensated result on the out_strobe cycle, in order. A local model of the
// integer compensation predicts each result when its set is transferred, and
// the monitor compares the strobed fields with the oldest prediction.
// Calibration words are rewritten between phases, only while the pipe is empty.

module tb;
  import esc_pkg::*;

  // Result of one reading set.
  typedef struct {
    logic [31:0] temp_centi;
    logic [31:0] press_q8;
    logic        press_ok;
    logic [16:0] hum_q10;
  } comp_res_t;

  typedef struct {
    logic [19:0] temp;
    logic [19:0] press;
    logic [15:0] hum;
  } raw_set_t;

  localparam int PIPE_DRAIN   = 100;     // more than the block's pipeline depth
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        start = 1'b0;
  logic        busy;
  logic [19:0] in_raw_temp = '0;
  logic [19:0] in_raw_press = '0;
  logic [15:0] in_raw_hum = '0;

  logic        out_strobe;
  logic [31:0] out_temp_centi;
  logic [31:0] out_press_q8;
  logic        out_press_ok;
  logic [16:0] out_hum_q10;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // Local copy of the calibration words, updated on each config transfer.
  logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
  logic [31:0] cal_ha, cal_hb;

  raw_set_t  pending_sets[$];
  comp_res_t expected_res[$];
  int        send_idle_pct = 0;
  int        mismatches = 0;
  int        cycle_cnt = 0;

  env_sensor_compensation u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_raw_temp    (in_raw_temp),
    .in_raw_press   (in_raw_press),
    .in_raw_hum     (in_raw_hum),
    .out_strobe     (out_strobe),
    .out_temp_centi (out_temp_centi),
    .out_press_q8   (out_press_q8),
    .out_press_ok   (out_press_ok),
    .out_hum_q10    (out_hum_q10),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // signed divide, truncating toward zero, divisor nonzero
  function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
    logic [63:0] nm, dm, qm;
    nm = n[63] ? -n : n;
    dm = d[63] ? -d : d;
    qm = nm / dm;
    return (n[63] != d[63]) ? -qm : qm;
  endfunction

  function automatic comp_res_t compensate(raw_set_t s);
    comp_res_t r;
    logic [31:0] at, ah, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] d, v1, v2, tf, x, hx, hy, hz, hw, hv, q;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, p, sc, c1, c2;
    at = {12'd0, s.temp};
    ah = {16'd0, s.hum};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = 32'(sext16(cal_temp[31:16]));
    t3 = 32'(sext16(cal_temp[47:32]));
    p1 = {48'd0, cal_pa[15:0]};
    p2 = sext16(cal_pa[31:16]);
    p3 = sext16(cal_pa[47:32]);
    p4 = sext16(cal_pb[15:0]);
    p5 = sext16(cal_pb[31:16]);
    p6 = sext16(cal_pb[47:32]);
    p7 = sext16(cal_pc[15:0]);
    p8 = sext16(cal_pc[31:16]);
    p9 = sext16(cal_pc[47:32]);
    h1 = {24'd0, cal_ha[7:0]};
    h2 = 32'(sext16(cal_ha[23:8]));
    h3 = {24'd0, cal_ha[31:24]};
    h4 = sext12(cal_hb[11:0]);
    h5 = sext12(cal_hb[23:12]);
    h6 = {{24{cal_hb[31]}}, cal_hb[31:24]};

    // temperature, fine term wraps at 32 bits
    d  = (at >> 4) - t1;
    v1 = asr32(((at >> 3) - (t1 << 1)) * t2, 11);
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    tf = v1 + v2;
    r.temp_centi = asr32(tf * 32'd5 + 32'd128, 8);

    // pressure, 64-bit wrap
    a = {{32{tf[31]}}, tf} - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = asr64(a * a * p3, 8) + ((a * p2) << 12);
    a = asr64(((64'd1 << 47) + a) * p1, 33);
    r.press_q8 = '0;
    r.press_ok = 1'b0;
    if (a != 0) begin
      p  = 64'd1048576 - {44'd0, s.press};
      p  = div_trunc(((p << 31) - b) * 64'd3125, a);
      sc = asr64(p, 13);
      c1 = asr64(p9 * sc * sc, 25);
      c2 = asr64(p8 * p, 19);
      p  = asr64(p + c1 + c2, 8) + (p7 << 4);
      if (p[63])
        r.press_q8 = '0;
      else if (p > 64'hFFFF_FFFF)
        r.press_q8 = 32'hFFFF_FFFF;
      else
        r.press_q8 = p[31:0];
      r.press_ok = 1'b1;
    end

    // humidity, 32-bit wrap, then clamp
    x  = tf - 32'd76800;
    hx = asr32((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    hy = asr32(x * h6, 10);
    hz = asr32(x * h3, 11) + 32'd32768;
    hw = asr32(hy * hz, 10) + 32'd2097152;
    hv = asr32(hw * h2 + 32'd8192, 14);
    x  = hx * hv;
    q  = asr32(x, 15);
    x  = x - asr32(asr32(q * q, 7) * h1, 4);
    if (x[31])
      x = '0;
    else if (x > HUM_MAX)
      x = HUM_MAX;
    r.hum_q10 = x[28:12];
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  // start stays high across back-to-back transfers; a transfer is predicted
  // at the edge that takes it.
  always @(posedge clk) begin
    raw_set_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_res.push_back(compensate('{in_raw_temp, in_raw_press, in_raw_hum}));
      if ((!start || !busy) ) begin
        if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_sets.pop_front();
          start        <= 1'b1;
          in_raw_temp  <= nxt.temp;
          in_raw_press <= nxt.press;
          in_raw_hum   <= nxt.hum;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    comp_res_t e;
    if (rst_n && out_strobe) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: temp %0d press %h ok %b hum %0d",
                   $signed(out_temp_centi), out_press_q8, out_press_ok, out_hum_q10);
      end else begin
        e = expected_res.pop_front();
        if (out_temp_centi !== e.temp_centi || out_press_q8 !== e.press_q8 ||
            out_press_ok !== e.press_ok || out_hum_q10 !== e.hum_q10) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp temp %0d press %h ok %b hum %0d / got %0d %h %b %0d",
                     $signed(e.temp_centi), e.press_q8, e.press_ok, e.hum_q10,
                     $signed(out_temp_centi), out_press_q8, out_press_ok, out_hum_q10);
        end
      end
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // transfer happened at this edge; mirror it
    case (idx)
      REG_TEMP_CAL:    cal_temp = data;
      REG_PRESS_CAL_A: cal_pa = data;
      REG_PRESS_CAL_B: cal_pb = data;
      REG_PRESS_CAL_C: cal_pc = data;
      REG_HUM_CAL_A:   cal_ha = data[31:0];
      REG_HUM_CAL_B:   cal_hb = data[31:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // T, P and H words in the usual device range
  task automatic load_typical(bit jitter);
    logic [47:0] w[6];
    w[0] = {16'hFC18, 16'd26435, 16'd27504};
    w[1] = {16'd3024, 16'hD643, 16'd36477};
    w[2] = {16'hFFF9, 16'd140, 16'd2855};
    w[3] = {16'd6000, 16'hC6F8, 16'd15500};
    w[4] = {16'd0, 8'd0, 16'd362, 8'd75};
    w[5] = {16'd0, 8'd30, 12'd50, 12'd313};
    for (int i = 0; i < 6; i++) begin
      if (jitter)
        w[i] = w[i] ^ {13'd0, 4'($urandom_range(15)), 12'd0,
                       4'($urandom_range(15)), 12'd0, 3'($urandom_range(7))};
      write_reg(CFG_IDX_W'(i), w[i]);
    end
  endtask

  task automatic load_all(logic [47:0] v);
    for (int i = 0; i < 6; i++)
      write_reg(CFG_IDX_W'(i), v);
  endtask

  function automatic raw_set_t rand_set();
    raw_set_t s;
    if ($urandom_range(1)) begin
      s.temp  = 20'($urandom);
      s.press = 20'($urandom);
      s.hum   = 16'($urandom);
    end else begin
      // near a normal room reading
      s.temp  = 20'(519888 + $urandom_range(65535) - 32768);
      s.press = 20'(415148 + $urandom_range(131071) - 65536);
      s.hum   = 16'(20000 + $urandom_range(30000));
    end
    return s;
  endfunction

  task automatic run_phase(int n, int idle);
    send_idle_pct = idle;
    for (int i = 0; i < n; i++)
      pending_sets.push_back(rand_set());
    wait_drained();
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_sets.size() > 0 || start || expected_res.size() > 0)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  initial begin
    logic [19:0] edges20[4];
    logic [15:0] edges16[3];
    int idles[4];
    edges20 = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    edges16 = '{16'h0000, 16'hFFFF, 16'h8000};
    idles   = '{0, 61, 0, 21};
    cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_ha = '0; cal_hb = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: divisor is zero, pressure invalid
    pending_sets.push_back('{20'h00000, 20'h00000, 16'h0000});
    pending_sets.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    wait_drained();

    // directed field extremes under typical calibration
    load_typical(1'b0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        pending_sets.push_back('{edges20[i], edges20[j], edges16[j % 3]});
    pending_sets.push_back('{20'd519888, 20'd415148, 16'd30000});
    pending_sets.push_back('{20'd519888, 20'd415148, 16'hFFFF});
    wait_drained();

    // index past the list is dropped
    write_reg(CFG_IDX_W'(6), 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_IDX_W'(7), 48'h1234_5678_9ABC);
    run_phase(20, 0);

    // random phases over several calibration settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 4: load_typical(1'b0);
        1, 5: load_typical(1'b1);
        2: load_all(48'hFFFF_FFFF_FFFF);
        3: load_all(48'h7FFF_7FFF_7FFF);
        6: begin
          load_typical(1'b1);
          write_reg(REG_PRESS_CAL_A, {32'($urandom), 16'd0});  // zero divisor
        end
        default: for (int i = 0; i < 6; i++)
          write_reg(CFG_IDX_W'(i), {16'($urandom), 32'($urandom)});
      endcase
      run_phase(176, idles[ph % 4]);
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
